@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sine and cosine block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// scp_pkg
// Types, constants and the rounding shift shared by the sine and cosine block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scp_pkg;

    localparam int WORK_FRAC = 30;

    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic signed [35:0] TWO_PI_Q32     = 36'sd26986075409;
    localparam logic signed [35:0] PI_Q32         = 36'sd13493037705;
    localparam logic signed [35:0] HALF_PI_Q32    = 36'sd6746518852;

    typedef logic signed [31:0] t_coef;

    localparam t_coef SIN_COEF [6] = '{
        -32'sd26, 32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
    };
    localparam t_coef COS_COEF [6] = '{
        -32'sd280, 32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
    };

    typedef struct packed {
        logic valid;
        logic neg_cos;
    } t_ctl;

    // Arithmetic right shift that rounds half away from zero.
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] half;
        logic signed [63:0] corr;
        if (s == 0) begin
            return v;
        end
        half = 64'sd1 <<< (s - 1);
        corr = v[63] ? 64'sd1 : 64'sd0;
        return (v + half - corr) >>> s;
    endfunction

endpackage

@@ hw/rtl/scp_reduce.sv @@
// ----------------------------------------------------------------------------
// scp_reduce
// Eight-stage range reduction: turn count, subtraction of whole turns, fold
// into the half circle, rounding to Q30 and squaring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_reduce #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_angle,
    output scp_pkg::t_ctl       o_ctl,
    output logic signed [31:0]  o_y,
    output logic signed [32:0]  o_z
);
    import scp_pkg::*;

    localparam int QW = 32 - ANGLE_FRAC_BITS;
    localparam int unsigned TURN_SHIFT = ANGLE_FRAC_BITS + 32;
    localparam int unsigned ANGLE_UP = 32 - ANGLE_FRAC_BITS;

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    t_ctl               r5_ctl, r6_ctl, r7_ctl, r8_ctl;
    logic signed [31:0] r1_a, r2_a, r3_a;
    logic signed [63:0] r1_prod;
    logic signed [QW-1:0] r2_q;
    logic signed [63:0] r3_qprod;
    logic signed [35:0] r4_x;
    logic signed [35:0] r5_x;
    logic signed [31:0] r6_y, r7_y, r8_y;
    logic signed [63:0] r7_sq;
    logic signed [32:0] r8_z;

    logic signed [63:0] n2_q_full;
    logic signed [63:0] n4_diff;
    logic signed [35:0] n5_x;
    logic               n5_neg;
    logic signed [63:0] n6_y_full;
    logic signed [63:0] n8_z_full;

    always_comb begin
        n2_q_full = shr_round(r1_prod, TURN_SHIFT);
        n4_diff   = (64'(r3_a) <<< ANGLE_UP) - r3_qprod;
        n5_x      = r4_x;
        n5_neg    = 1'b0;
        if (r4_x > HALF_PI_Q32) begin
            n5_x   = PI_Q32 - r4_x;
            n5_neg = 1'b1;
        end else if (r4_x < -HALF_PI_Q32) begin
            n5_x   = -PI_Q32 - r4_x;
            n5_neg = 1'b1;
        end
        n6_y_full = shr_round(64'(r5_x), 32 - WORK_FRAC);
        n8_z_full = shr_round(r7_sq, WORK_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_ctl <= '0;
            r6_ctl <= '0;
            r7_ctl <= '0;
            r8_ctl <= '0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_ctl <= '{valid: r4_vld, neg_cos: n5_neg};
            r6_ctl <= r5_ctl;
            r7_ctl <= r6_ctl;
            r8_ctl <= r7_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= i_angle;
            r1_prod  <= 64'(i_angle) * 64'(INV_TWO_PI_Q32);
            r2_a     <= r1_a;
            r2_q     <= n2_q_full[QW-1:0];
            r3_a     <= r2_a;
            r3_qprod <= 64'(r2_q) * 64'(TWO_PI_Q32);
            r4_x     <= n4_diff[35:0];
            r5_x     <= n5_x;
            r6_y     <= n6_y_full[31:0];
            r7_y     <= r6_y;
            r7_sq    <= 64'(r6_y) * 64'(r6_y);
            r8_y     <= r7_y;
            r8_z     <= n8_z_full[32:0];
        end
    end

    assign o_ctl = r8_ctl;
    assign o_y   = r8_y;
    assign o_z   = r8_z;

endmodule

@@ hw/rtl/scp_horner_step.sv @@
// ----------------------------------------------------------------------------
// scp_horner_step
// One Horner step for both polynomials: a multiply stage, then a stage that
// rounds the product back to Q30 and adds the next coefficient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_horner_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  scp_pkg::t_ctl       i_ctl,
    input  logic signed [31:0]  i_y,
    input  logic signed [32:0]  i_z,
    input  logic signed [31:0]  i_sin_acc,
    input  logic signed [31:0]  i_cos_acc,
    input  logic signed [31:0]  i_sin_coef,
    input  logic signed [31:0]  i_cos_coef,
    output scp_pkg::t_ctl       o_ctl,
    output logic signed [31:0]  o_y,
    output logic signed [32:0]  o_z,
    output logic signed [31:0]  o_sin_acc,
    output logic signed [31:0]  o_cos_acc
);
    import scp_pkg::*;

    t_ctl               r1_ctl, r2_ctl;
    logic signed [31:0] r1_y, r2_y;
    logic signed [32:0] r1_z, r2_z;
    logic signed [63:0] r1_sin_prod, r1_cos_prod;
    logic signed [31:0] r2_sin_acc, r2_cos_acc;

    logic signed [63:0] n2_sin_full, n2_cos_full;

    always_comb begin
        n2_sin_full = shr_round(r1_sin_prod, WORK_FRAC) + 64'(i_sin_coef);
        n2_cos_full = shr_round(r1_cos_prod, WORK_FRAC) + 64'(i_cos_coef);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_y        <= i_y;
            r1_z        <= i_z;
            r1_sin_prod <= 64'(i_sin_acc) * 64'(i_z);
            r1_cos_prod <= 64'(i_cos_acc) * 64'(i_z);
            r2_y        <= r1_y;
            r2_z        <= r1_z;
            r2_sin_acc  <= n2_sin_full[31:0];
            r2_cos_acc  <= n2_cos_full[31:0];
        end
    end

    assign o_ctl     = r2_ctl;
    assign o_y       = r2_y;
    assign o_z       = r2_z;
    assign o_sin_acc = r2_sin_acc;
    assign o_cos_acc = r2_cos_acc;

endmodule

@@ hw/rtl/scp_finish.sv @@
// ----------------------------------------------------------------------------
// scp_finish
// Three-stage output end: the last sine product, the cosine sign, rounding to
// the output format and clipping to plus or minus one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scp_finish #(
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  scp_pkg::t_ctl       i_ctl,
    input  logic signed [31:0]  i_y,
    input  logic signed [31:0]  i_sin_acc,
    input  logic signed [31:0]  i_cos_acc,
    output scp_pkg::t_ctl       o_ctl,
    output logic signed [31:0]  o_sine,
    output logic signed [31:0]  o_cosine
);
    import scp_pkg::*;

    localparam int unsigned OUT_SHIFT = WORK_FRAC - RESULT_FRAC_BITS;
    localparam logic signed [63:0] LIM = 64'sd1 <<< RESULT_FRAC_BITS;

    t_ctl               r1_ctl, r2_ctl, r3_ctl;
    logic signed [63:0] r1_sin_prod;
    logic signed [31:0] r1_cos, r2_cos;
    logic signed [31:0] r2_sin;
    logic signed [31:0] r3_sin, r3_cos;

    logic signed [63:0] n2_sin_full;
    logic signed [63:0] n3_sin_full, n3_cos_full;

    function automatic logic signed [63:0] clip(input logic signed [63:0] v);
        if (v > LIM) begin
            return LIM;
        end
        if (v < -LIM) begin
            return -LIM;
        end
        return v;
    endfunction

    always_comb begin
        n2_sin_full = shr_round(r1_sin_prod, WORK_FRAC);
        n3_sin_full = clip(shr_round(64'(r2_sin), OUT_SHIFT));
        n3_cos_full = clip(shr_round(64'(r2_cos), OUT_SHIFT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sin_prod <= 64'(i_sin_acc) * 64'(i_y);
            r1_cos      <= i_ctl.neg_cos ? -i_cos_acc : i_cos_acc;
            r2_sin      <= n2_sin_full[31:0];
            r2_cos      <= r1_cos;
            r3_sin      <= n3_sin_full[31:0];
            r3_cos      <= n3_cos_full[31:0];
        end
    end

    assign o_ctl    = r3_ctl;
    assign o_sine   = r3_sin;
    assign o_cosine = r3_cos;

endmodule

@@ hw/rtl/sine_cosine_polynomial.sv @@
// ----------------------------------------------------------------------------
// sine_cosine_polynomial
// Sine and cosine of a fixed-point angle by range reduction and minimax
// polynomials, in a 21-stage pipeline.
//
//   Channel   Direction   Handshake             Payload
//   input     in          i_valid / o_ready     i_angle
//   output    out         o_valid / i_ready     o_sine_out, o_cosine_out
//
// One transaction is accepted every cycle while the pipeline flows.
// The pipeline is made of eight reduction stages, five two-stage Horner steps
// and three output stages, with each multiplier followed by a register.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Reset clears the valid and cosine-sign control bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_polynomial #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_angle,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_sine_out,
    output logic signed [31:0]  o_cosine_out
);
    import scp_pkg::*;

`include "assert_macros.svh"

    localparam logic signed [31:0] OUT_LIM = 32'sd1 <<< RESULT_FRAC_BITS;

    logic               w_en;
    t_ctl               w_ctl     [6];
    logic signed [31:0] w_y       [6];
    logic signed [32:0] w_z       [6];
    logic signed [31:0] w_sin_acc [6];
    logic signed [31:0] w_cos_acc [6];
    t_ctl               w_fin_ctl;

    assign w_en    = ~w_fin_ctl.valid | i_ready;
    assign o_ready = w_en;
    assign o_valid = w_fin_ctl.valid;

    scp_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_angle (i_angle),
        .o_ctl   (w_ctl[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    assign w_sin_acc[0] = SIN_COEF[0];
    assign w_cos_acc[0] = COS_COEF[0];

    for (genvar k = 1; k < 6; k++) begin : g_horner
        scp_horner_step u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_ctl      (w_ctl[k-1]),
            .i_y        (w_y[k-1]),
            .i_z        (w_z[k-1]),
            .i_sin_acc  (w_sin_acc[k-1]),
            .i_cos_acc  (w_cos_acc[k-1]),
            .i_sin_coef (SIN_COEF[k]),
            .i_cos_coef (COS_COEF[k]),
            .o_ctl      (w_ctl[k]),
            .o_y        (w_y[k]),
            .o_z        (w_z[k]),
            .o_sin_acc  (w_sin_acc[k]),
            .o_cos_acc  (w_cos_acc[k])
        );
    end

    scp_finish #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_ctl     (w_ctl[5]),
        .i_y       (w_y[5]),
        .i_sin_acc (w_sin_acc[5]),
        .i_cos_acc (w_cos_acc[5]),
        .o_ctl     (w_fin_ctl),
        .o_sine    (o_sine_out),
        .o_cosine  (o_cosine_out)
    );

    `SCP_ASSERT_IMP(a_sine_range, i_clk, i_rst_n, o_valid,
        (o_sine_out <= OUT_LIM) && (o_sine_out >= -OUT_LIM), "sine result beyond one")
    `SCP_ASSERT_IMP(a_cosine_range, i_clk, i_rst_n, o_valid,
        (o_cosine_out <= OUT_LIM) && (o_cosine_out >= -OUT_LIM), "cosine result beyond one")
    `SCP_ASSERT_NXT(a_stall_freeze, i_clk, i_rst_n, !o_ready,
        $stable(w_ctl[0]) && $stable(w_ctl[5]), "pipeline moved during a stall")

endmodule

@@ test/sine_cosine_polynomial_tb.sv @@
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_tb
// Self-checking bench for the fixed-point sine and cosine pipeline. A clocked
// driver feeds angles from a queue of pending transactions. A clocked monitor
// computes the expected sine and cosine of each accepted angle in 64-bit
// fixed point and checks every result in order. Directed angles come first,
// then random ones. Both sides idle at random, and the sender sometimes waits
// for the pipeline to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_polynomial_tb;

    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;
    localparam int POLY_FRAC        = 30;
    localparam int RANDOM_ANGLES    = 500;
    localparam int MAX_IDLE         = 18;
    localparam int PIPE_DEPTH       = 21;
    localparam int CYCLE_LIMIT      = 200000;

    localparam longint TURNS_PER_RAD_Q32 = 64'sd683565276;
    localparam longint TWO_PI_Q32        = 64'sd26986075409;
    localparam longint PI_Q32            = 64'sd13493037705;
    localparam longint HALF_PI_Q32       = 64'sd6746518852;

    localparam int PI_ANGLE      = 52707179;
    localparam int HALF_PI_ANGLE = 26353589;
    localparam int TWO_PI_ANGLE  = 105414357;

    typedef struct {
        logic signed [31:0] angle;
        bit                 drain_first;
    } t_angle_txn;

    typedef struct {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } t_sincos;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_angle = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_sine_out;
    logic signed [31:0] o_cosine_out;

    t_angle_txn pending_angles[$];
    t_sincos    sincos_expected[$];

    logic       angle_fire  = 1'b0;
    logic       result_fire = 1'b0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    int         send_gap = 0;
    bit         send_burst = 1'b0;
    logic       valid_next;
    t_angle_txn next_txn;

    int         recv_stall = 0;
    bit         recv_burst = 1'b0;
    logic       ready_next;

    t_sincos    predicted;
    t_sincos    oldest;

    sine_cosine_polynomial #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_angle      (i_angle),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sine_out   (o_sine_out),
        .o_cosine_out (o_cosine_out)
    );

    function automatic longint round_shift(input longint v, input int s);
        longint half;
        if (s == 0) begin
            return v;
        end
        half = longint'(1) <<< (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return round_shift(a * b, POLY_FRAC);
    endfunction

    function automatic longint horner_eval(input longint k0, input longint k1,
                                           input longint k2, input longint k3,
                                           input longint k4, input longint k5,
                                           input longint z);
        longint acc;
        acc = k0;
        acc = fx_mul(acc, z) + k1;
        acc = fx_mul(acc, z) + k2;
        acc = fx_mul(acc, z) + k3;
        acc = fx_mul(acc, z) + k4;
        acc = fx_mul(acc, z) + k5;
        return acc;
    endfunction

    function automatic logic signed [31:0] clip_unit(input longint v);
        longint unit_val;
        longint r;
        unit_val = longint'(1) <<< RESULT_FRAC_BITS;
        r = round_shift(v, POLY_FRAC - RESULT_FRAC_BITS);
        if (r > unit_val) begin
            r = unit_val;
        end
        if (r < -unit_val) begin
            r = -unit_val;
        end
        return r[31:0];
    endfunction

    function automatic t_sincos predict_sincos(input logic signed [31:0] angle);
        t_sincos res;
        longint  a;
        longint  turns;
        longint  red;
        longint  y;
        longint  z;
        longint  s;
        longint  c;
        bit      mirrored;
        a = longint'(angle);
        mirrored = 1'b0;
        turns = round_shift(a * TURNS_PER_RAD_Q32, ANGLE_FRAC_BITS + 32);
        red = a * (longint'(1) <<< (32 - ANGLE_FRAC_BITS)) - turns * TWO_PI_Q32;
        if (red > HALF_PI_Q32) begin
            red = PI_Q32 - red;
            mirrored = 1'b1;
        end else if (red < -HALF_PI_Q32) begin
            red = -PI_Q32 - red;
            mirrored = 1'b1;
        end
        y = round_shift(red, 32 - POLY_FRAC);
        z = fx_mul(y, y);
        s = fx_mul(horner_eval(-26, 2956, -213040, 8947846, -178956974, 1073741824, z), y);
        c = horner_eval(-280, 26586, -1491253, 44739212, -536870912, 1073741824, z);
        if (mirrored) begin
            c = -c;
        end
        res.sine   = clip_unit(s);
        res.cosine = clip_unit(c);
        return res;
    endfunction

    function automatic void queue_angle(input logic signed [31:0] angle,
                                        input bit drain_first);
        t_angle_txn t;
        t.angle       = angle;
        t.drain_first = drain_first;
        pending_angles.push_back(t);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: presents one angle at a time and holds it until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            valid_next = i_valid;
            if (i_valid && angle_fire) begin
                valid_next = 1'b0;
            end
            if (!valid_next && pending_angles.size() != 0) begin
                if (pending_angles[0].drain_first && sincos_expected.size() != 0) begin
                    valid_next = 1'b0;
                end else if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else begin
                    next_txn = pending_angles.pop_front();
                    i_angle <= next_txn.angle;
                    valid_next = 1'b1;
                    if ($urandom_range(0, 31) == 0) begin
                        send_burst = !send_burst;
                    end
                    send_gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
                end
            end
            i_valid <= valid_next;
        end
    end

    // Receiver: stalls for a random number of cycles before each result.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            ready_next = i_ready;
            if (i_ready && result_fire) begin
                if ($urandom_range(0, 31) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
                ready_next = (recv_stall == 0);
            end else if (!i_ready) begin
                if (recv_stall > 0) begin
                    recv_stall = recv_stall - 1;
                end
                if (recv_stall == 0) begin
                    ready_next = 1'b1;
                end
            end
            i_ready <= ready_next;
        end
    end

    // Monitor: predicts each accepted angle and checks each result in order.
    always @(posedge i_clk) begin
        angle_fire  <= i_rst_n && i_valid && o_ready;
        result_fire <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && i_valid && o_ready) begin
            predicted = predict_sincos(i_angle);
            sincos_expected.push_back(predicted);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (sincos_expected.size() == 0) begin
                $display("%0t: unexpected result, sine %0d cosine %0d",
                         $time, o_sine_out, o_cosine_out);
                mismatch_count = mismatch_count + 1;
            end else begin
                oldest = sincos_expected.pop_front();
                if (o_sine_out !== oldest.sine) begin
                    $display("%0t: sine_out expected %0d actual %0d",
                             $time, oldest.sine, o_sine_out);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_cosine_out !== oldest.cosine) begin
                    $display("%0t: cosine_out expected %0d actual %0d",
                             $time, oldest.cosine, o_cosine_out);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sine_cosine_polynomial: mismatch");
            $finish;
        end
    end

    initial begin
        int     pick;
        int     k;
        int     offset;
        longint near;

        // Extremes, quadrant boundaries and the half turn on either side.
        queue_angle(32'sd0, 1'b0);
        queue_angle(32'sd1, 1'b0);
        queue_angle(-32'sd1, 1'b0);
        queue_angle(32'sh7FFF_FFFF, 1'b0);
        queue_angle(32'sh8000_0000, 1'b0);
        queue_angle(32'sh5555_5555, 1'b0);
        queue_angle(32'shAAAA_AAAA, 1'b0);
        queue_angle(32'sd1 <<< ANGLE_FRAC_BITS, 1'b0);
        queue_angle(PI_ANGLE, 1'b0);
        queue_angle(-PI_ANGLE, 1'b0);
        queue_angle(PI_ANGLE - 1, 1'b0);
        queue_angle(PI_ANGLE + 1, 1'b0);
        queue_angle(-PI_ANGLE + 1, 1'b0);
        queue_angle(-PI_ANGLE - 1, 1'b0);
        queue_angle(HALF_PI_ANGLE, 1'b0);
        queue_angle(-HALF_PI_ANGLE, 1'b0);
        queue_angle(HALF_PI_ANGLE + 1, 1'b0);
        queue_angle(-HALF_PI_ANGLE - 1, 1'b0);
        queue_angle(TWO_PI_ANGLE, 1'b0);
        queue_angle(-TWO_PI_ANGLE, 1'b0);
        queue_angle(3 * PI_ANGLE, 1'b0);
        queue_angle(-3 * PI_ANGLE, 1'b0);
        queue_angle(HALF_PI_ANGLE - 100, 1'b0);

        for (int n = 0; n < RANDOM_ANGLES; n++) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: near = longint'($signed($urandom));
                1: near = longint'($urandom_range(0, 32'h0FFF_FFFF)) - 64'sh0800_0000;
                2: begin
                    k = $urandom_range(0, 162);
                    offset = $urandom_range(0, 128);
                    near = longint'(k - 81) * longint'(HALF_PI_ANGLE) +
                           longint'(offset - 64);
                end
                default: near = longint'($urandom_range(0, 32'h0001_FFFF)) - 64'sh0001_0000;
            endcase
            queue_angle(near[31:0], (n == 0) || (n == RANDOM_ANGLES / 2) ||
                                    ($urandom_range(0, 99) == 0));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_angles.size() != 0 || i_valid || sincos_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sine_cosine_polynomial: match");
        end else begin
            $display("sine_cosine_polynomial: mismatch");
        end
        $finish;
    end

endmodule
